[rtl/core/distance_constraint_solver_assert.svh]
// ----------------------------------------------------------------------------
// distance constraint solver assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_CONSTRAINT_SOLVER_ASSERT_SVH
`define DISTANCE_CONSTRAINT_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define DCS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("distance constraint solver assertion failed");
// next-cycle implication
`define DCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("distance constraint solver assertion failed");
`else
`define DCS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define DCS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/dcs_pkg.sv]
// ----------------------------------------------------------------------------
// dcs_pkg
// Field widths and fixed-point constants of the distance constraint solver.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int REST_W          = 31;
   localparam int STIFF_W         = 17;
   localparam int MASS_W          = 24;
   localparam int SPROD_W         = STIFF_W + MASS_W;
   localparam int QUO_W           = REST_W + 16;
   localparam int K_W             = 33;
   localparam int ROOT_STEPS      = 32;

   localparam logic [STIFF_W-1:0] STIFF_ONE   = STIFF_W'(65536);
   localparam logic [QUO_W-1:0]   Q_ONE       = QUO_W'(65536);
   // largest quotient kept: ratio of 2^31 - 1 plus one
   localparam logic [QUO_W-1:0]   Q_CAP       = QUO_W'(64'd2147549183);

endpackage

`default_nettype wire

[rtl/core/distance_constraint_solver.sv]
// ----------------------------------------------------------------------------
// distance_constraint_solver
// Pipelined position-based distance constraint, one link per cycle unless stalled.
// ----------------------------------------------------------------------------
// One link enters per cycle while the pipeline advances. It holds the 32-stage
// square root and the 47-stage restoring divider, one result bit per stage.
// The whole pipeline advances together and holds while a finished result is
// not taken. Coincident points or two zero inverse masses pass both positions
// through with rsp_degenerate high.
`default_nettype none

`include "distance_constraint_solver_assert.svh"

module distance_constraint_solver #(
   parameter int COORD_WIDTH = dcs_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [COORD_WIDTH-1:0]         req_in_a_x,
   input  wire logic [COORD_WIDTH-1:0]         req_in_a_y,
   input  wire logic [COORD_WIDTH-1:0]         req_in_a_z,
   input  wire logic [COORD_WIDTH-1:0]         req_in_b_x,
   input  wire logic [COORD_WIDTH-1:0]         req_in_b_y,
   input  wire logic [COORD_WIDTH-1:0]         req_in_b_z,
   input  wire logic [dcs_pkg::REST_W-1:0]     req_rest_length,
   input  wire logic [dcs_pkg::STIFF_W-1:0]    req_stiffness,
   input  wire logic [dcs_pkg::MASS_W-1:0]     req_inv_mass_a,
   input  wire logic [dcs_pkg::MASS_W-1:0]     req_inv_mass_b,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [COORD_WIDTH-1:0]              rsp_out_a_x,
   output logic [COORD_WIDTH-1:0]              rsp_out_a_y,
   output logic [COORD_WIDTH-1:0]              rsp_out_a_z,
   output logic [COORD_WIDTH-1:0]              rsp_out_b_x,
   output logic [COORD_WIDTH-1:0]              rsp_out_b_y,
   output logic [COORD_WIDTH-1:0]              rsp_out_b_z,
   output logic                                rsp_degenerate
);

   import dcs_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;
   localparam int MAXSH = (DW > 31) ? DW - 31 : 0;
   localparam int SW    = (MAXSH > 0) ? $clog2(MAXSH + 1) : 1;
   localparam int LW    = 32 + MAXSH;
   localparam int DLW   = (DW + 1) / 2;
   localparam int DHW   = DW - DLW;
   localparam int FW    = DW + K_W;
   localparam int CW    = (FW > 64) ? FW : 64;

   // stage map
   localparam int ST_DIFF  = 1;
   localparam int ST_NORM  = 2;
   localparam int ST_SQR   = 3;
   localparam int ST_SUM   = 4;
   localparam int ST_ROOT  = 5;
   localparam int ST_LEN   = ST_ROOT + ROOT_STEPS;
   localparam int ST_DIV   = ST_LEN + 1;
   localparam int ST_RATIO = ST_DIV + QUO_W;
   localparam int ST_GAIN  = ST_RATIO + 1;
   localparam int ST_PART  = ST_GAIN + 1;
   localparam int ST_MERGE = ST_PART + 1;
   localparam int ST_OUT   = ST_MERGE + 1;
   localparam int NS       = ST_OUT + 1;

   localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

   typedef struct packed {
      logic [2:0][W-1:0]           a;
      logic [2:0][W-1:0]           b;
      logic [2:0]                  dneg;
      logic [2:0][DW-1:0]          dmag;
      logic [REST_W-1:0]           rest;
      logic [STIFF_W-1:0]          stiff;
      logic [MASS_W-1:0]           ima;
      logic [MASS_W-1:0]           imb;
      logic [MASS_W:0]             msum;
      logic [SPROD_W-1:0]          sprod;
      logic [SW-1:0]               sh;
      logic [2:0][30:0]            m;
      logic [2:0][61:0]            sq;
      logic [63:0]                 rrem;
      logic [63:0]                 rres;
      logic [LW-1:0]               len;
      logic                        degen;
      logic [LW-1:0]               qrem;
      logic [QUO_W-1:0]            quo;
      logic [MASS_W:0]             srem;
      logic [SPROD_W-1:0]          squo;
      logic [STIFF_W-1:0]          s1;
      logic [STIFF_W-1:0]          s2;
      logic                        rneg;
      logic [31:0]                 rmag;
      logic [K_W-1:0]              ka;
      logic [K_W-1:0]              kb;
      logic [2:0][DLW+K_W-1:0]     pal;
      logic [2:0][DHW+K_W-1:0]     pah;
      logic [2:0][DLW+K_W-1:0]     pbl;
      logic [2:0][DHW+K_W-1:0]     pbh;
      logic [2:0][62:0]            dam;
      logic [2:0][62:0]            dbm;
      logic [2:0][W-1:0]           oa;
      logic [2:0][W-1:0]           ob;
   } pipe_type;

   pipe_type          st_ff [NS];
   pipe_type          st_in [NS];
   logic [NS-1:0]     vld_ff;
   logic [NS-1:0]     vld_in;
   logic              adv;

   assign adv       = !vld_ff[NS-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NS-2:0], req_valid};

   // input register
   always_comb begin
      st_in[0]         = '0;
      st_in[0].a[0]    = req_in_a_x;
      st_in[0].a[1]    = req_in_a_y;
      st_in[0].a[2]    = req_in_a_z;
      st_in[0].b[0]    = req_in_b_x;
      st_in[0].b[1]    = req_in_b_y;
      st_in[0].b[2]    = req_in_b_z;
      st_in[0].rest    = req_rest_length;
      st_in[0].stiff   = req_stiffness;
      st_in[0].ima     = req_inv_mass_a;
      st_in[0].imb     = req_inv_mass_b;
   end

   // separation, stiffness clamp, mass sum, stiffness share numerator
   always_comb begin
      logic [DW-1:0]      diff;
      logic [STIFF_W-1:0] stc;
      st_in[ST_DIFF] = st_ff[ST_DIFF-1];
      for (int i = 0; i < 3; i++) begin
         diff = DW'($signed(st_ff[ST_DIFF-1].a[i])) - DW'($signed(st_ff[ST_DIFF-1].b[i]));
         st_in[ST_DIFF].dneg[i] = diff[DW-1];
         st_in[ST_DIFF].dmag[i] = diff[DW-1] ? (~diff + DW'(1)) : diff;
      end
      stc = (st_ff[ST_DIFF-1].stiff > STIFF_ONE) ? STIFF_ONE : st_ff[ST_DIFF-1].stiff;
      st_in[ST_DIFF].stiff = stc;
      st_in[ST_DIFF].msum  = {1'b0, st_ff[ST_DIFF-1].ima} + {1'b0, st_ff[ST_DIFF-1].imb};
      st_in[ST_DIFF].sprod = SPROD_W'(stc) * SPROD_W'(st_ff[ST_DIFF-1].ima);
   end

   // scale so every magnitude fits 31 bits
   always_comb begin
      logic [DW-1:0] mx;
      logic [SW-1:0] shv;
      st_in[ST_NORM] = st_ff[ST_NORM-1];
      mx = st_ff[ST_NORM-1].dmag[0];
      if (st_ff[ST_NORM-1].dmag[1] > mx) mx = st_ff[ST_NORM-1].dmag[1];
      if (st_ff[ST_NORM-1].dmag[2] > mx) mx = st_ff[ST_NORM-1].dmag[2];
      shv = SW'(MAXSH);
      for (int j = MAXSH; j >= 0; j--) begin
         if (((mx >> j) >> 31) == '0) shv = SW'(j);
      end
      st_in[ST_NORM].sh = shv;
      for (int i = 0; i < 3; i++) begin
         st_in[ST_NORM].m[i] = 31'(st_ff[ST_NORM-1].dmag[i] >> shv);
      end
   end

   always_comb begin
      st_in[ST_SQR] = st_ff[ST_SQR-1];
      for (int i = 0; i < 3; i++) begin
         st_in[ST_SQR].sq[i] = st_ff[ST_SQR-1].m[i] * st_ff[ST_SQR-1].m[i];
      end
   end

   always_comb begin
      st_in[ST_SUM]      = st_ff[ST_SUM-1];
      st_in[ST_SUM].rrem = 64'(st_ff[ST_SUM-1].sq[0]) + 64'(st_ff[ST_SUM-1].sq[1])
                         + 64'(st_ff[ST_SUM-1].sq[2]);
      st_in[ST_SUM].rres = '0;
   end

   // square root, two radicand bits per stage
   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [63:0] BITV = 64'(1) << (62 - 2 * k);
      always_comb begin
         logic [63:0] t;
         st_in[ST_ROOT+k] = st_ff[ST_ROOT+k-1];
         t = st_ff[ST_ROOT+k-1].rres + BITV;
         if (st_ff[ST_ROOT+k-1].rrem >= t) begin
            st_in[ST_ROOT+k].rrem = st_ff[ST_ROOT+k-1].rrem - t;
            st_in[ST_ROOT+k].rres = (st_ff[ST_ROOT+k-1].rres >> 1) + BITV;
         end else begin
            st_in[ST_ROOT+k].rres = st_ff[ST_ROOT+k-1].rres >> 1;
         end
      end
   end

   always_comb begin
      st_in[ST_LEN]       = st_ff[ST_LEN-1];
      st_in[ST_LEN].len   = LW'(st_ff[ST_LEN-1].rres[31:0]) << st_ff[ST_LEN-1].sh;
      st_in[ST_LEN].degen = (st_ff[ST_LEN-1].rres == '0) || (st_ff[ST_LEN-1].msum == '0);
      st_in[ST_LEN].qrem  = '0;
      st_in[ST_LEN].quo   = '0;
      st_in[ST_LEN].srem  = '0;
      st_in[ST_LEN].squo  = '0;
   end

   // restoring division: rest over length, and the stiffness share alongside
   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      always_comb begin
         logic          nbit;
         logic [LW:0]   trial;
         logic          sbit;
         logic [MASS_W+1:0] strial;
         st_in[ST_DIV+j] = st_ff[ST_DIV+j-1];
         nbit = (j < REST_W) ? st_ff[ST_DIV+j-1].rest[(j < REST_W) ? REST_W-1-j : 0] : 1'b0;
         trial = {st_ff[ST_DIV+j-1].qrem, nbit};
         if (trial >= {1'b0, st_ff[ST_DIV+j-1].len}) begin
            st_in[ST_DIV+j].qrem = LW'(trial - {1'b0, st_ff[ST_DIV+j-1].len});
            st_in[ST_DIV+j].quo[QUO_W-1-j] = 1'b1;
         end else begin
            st_in[ST_DIV+j].qrem = LW'(trial);
         end
         sbit = (j < SPROD_W) ?
            st_ff[ST_DIV+j-1].sprod[(j < SPROD_W) ? SPROD_W-1-j : 0] : 1'b0;
         strial = {st_ff[ST_DIV+j-1].srem, sbit};
         if (j < SPROD_W) begin
            if (strial >= {1'b0, st_ff[ST_DIV+j-1].msum}) begin
               st_in[ST_DIV+j].srem = (MASS_W+1)'(strial - {1'b0, st_ff[ST_DIV+j-1].msum});
               st_in[ST_DIV+j].squo[(j < SPROD_W) ? SPROD_W-1-j : 0] = 1'b1;
            end else begin
               st_in[ST_DIV+j].srem = (MASS_W+1)'(strial);
            end
         end
      end
   end

   // relative error and the two stiffness shares
   always_comb begin
      logic [QUO_W-1:0] qs;
      st_in[ST_RATIO] = st_ff[ST_RATIO-1];
      qs = (st_ff[ST_RATIO-1].quo > Q_CAP) ? Q_CAP : st_ff[ST_RATIO-1].quo;
      if (qs < Q_ONE) begin
         st_in[ST_RATIO].rneg = 1'b1;
         st_in[ST_RATIO].rmag = 32'(Q_ONE - qs);
      end else begin
         st_in[ST_RATIO].rneg = 1'b0;
         st_in[ST_RATIO].rmag = 32'(qs - Q_ONE);
      end
      st_in[ST_RATIO].s1 = st_ff[ST_RATIO-1].squo[STIFF_W-1:0];
      st_in[ST_RATIO].s2 = st_ff[ST_RATIO-1].stiff - st_ff[ST_RATIO-1].squo[STIFF_W-1:0];
   end

   always_comb begin
      logic [STIFF_W+31:0] pka;
      logic [STIFF_W+31:0] pkb;
      st_in[ST_GAIN] = st_ff[ST_GAIN-1];
      pka = st_ff[ST_GAIN-1].s1 * st_ff[ST_GAIN-1].rmag;
      pkb = st_ff[ST_GAIN-1].s2 * st_ff[ST_GAIN-1].rmag;
      st_in[ST_GAIN].ka = pka[STIFF_W+31:16];
      st_in[ST_GAIN].kb = pkb[STIFF_W+31:16];
   end

   // separation times gain, split in low and high partial products
   always_comb begin
      st_in[ST_PART] = st_ff[ST_PART-1];
      for (int i = 0; i < 3; i++) begin
         st_in[ST_PART].pal[i] = st_ff[ST_PART-1].dmag[i][DLW-1:0] * st_ff[ST_PART-1].ka;
         st_in[ST_PART].pah[i] = st_ff[ST_PART-1].dmag[i][DW-1:DLW] * st_ff[ST_PART-1].ka;
         st_in[ST_PART].pbl[i] = st_ff[ST_PART-1].dmag[i][DLW-1:0] * st_ff[ST_PART-1].kb;
         st_in[ST_PART].pbh[i] = st_ff[ST_PART-1].dmag[i][DW-1:DLW] * st_ff[ST_PART-1].kb;
      end
   end

   always_comb begin
      logic [CW-1:0] fa;
      logic [CW-1:0] fb;
      st_in[ST_MERGE] = st_ff[ST_MERGE-1];
      for (int i = 0; i < 3; i++) begin
         fa = ((CW'(st_ff[ST_MERGE-1].pah[i]) << DLW) + CW'(st_ff[ST_MERGE-1].pal[i])) >> 16;
         fb = ((CW'(st_ff[ST_MERGE-1].pbh[i]) << DLW) + CW'(st_ff[ST_MERGE-1].pbl[i])) >> 16;
         st_in[ST_MERGE].dam[i] = (fa > (CW'(1) << 62)) ? (63'(1) << 62) : fa[62:0];
         st_in[ST_MERGE].dbm[i] = (fb > (CW'(1) << 62)) ? (63'(1) << 62) : fb[62:0];
      end
   end

   // apply the moves and clamp to the coordinate range
   always_comb begin
      logic signed [63:0] av;
      logic signed [63:0] bv;
      logic signed [63:0] da;
      logic signed [63:0] db;
      logic               neg;
      st_in[ST_OUT] = st_ff[ST_OUT-1];
      for (int i = 0; i < 3; i++) begin
         neg = st_ff[ST_OUT-1].dneg[i] ^ st_ff[ST_OUT-1].rneg;
         da  = $signed({1'b0, st_ff[ST_OUT-1].dam[i]});
         db  = $signed({1'b0, st_ff[ST_OUT-1].dbm[i]});
         av  = 64'($signed(st_ff[ST_OUT-1].a[i])) + (neg ? -da : da);
         bv  = 64'($signed(st_ff[ST_OUT-1].b[i])) - (neg ? -db : db);
         if (av > SAT_HI)      av = SAT_HI;
         else if (av < SAT_LO) av = SAT_LO;
         if (bv > SAT_HI)      bv = SAT_HI;
         else if (bv < SAT_LO) bv = SAT_LO;
         if (st_ff[ST_OUT-1].degen) begin
            st_in[ST_OUT].oa[i] = st_ff[ST_OUT-1].a[i];
            st_in[ST_OUT].ob[i] = st_ff[ST_OUT-1].b[i];
         end else begin
            st_in[ST_OUT].oa[i] = av[W-1:0];
            st_in[ST_OUT].ob[i] = bv[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign rsp_valid      = vld_ff[NS-1];
   assign rsp_out_a_x    = st_ff[NS-1].oa[0];
   assign rsp_out_a_y    = st_ff[NS-1].oa[1];
   assign rsp_out_a_z    = st_ff[NS-1].oa[2];
   assign rsp_out_b_x    = st_ff[NS-1].ob[0];
   assign rsp_out_b_y    = st_ff[NS-1].ob[1];
   assign rsp_out_b_z    = st_ff[NS-1].ob[2];
   assign rsp_degenerate = st_ff[NS-1].degen;

   // a held pipeline keeps its occupancy
   `DCS_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(vld_ff))
   // integer root of a 64-bit sum fits 32 bits
   `DCS_ASSERT_IMPL(a_root_width, clock, reset, vld_ff[ST_LEN-1], st_ff[ST_LEN-1].rres[63:32] == '0)
   `DCS_ASSERT_IMPL(a_div_rem, clock, reset, vld_ff[ST_RATIO-1] && st_ff[ST_RATIO-1].len != '0, st_ff[ST_RATIO-1].qrem < st_ff[ST_RATIO-1].len)
   // share of point a never exceeds the full stiffness
   `DCS_ASSERT_IMPL(a_share, clock, reset, vld_ff[ST_RATIO] && !st_ff[ST_RATIO].degen, st_ff[ST_RATIO].s1 <= st_ff[ST_RATIO].stiff)

endmodule

`default_nettype wire

[tb/tb_distance_constraint_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_constraint_solver
// Drives link corrections through the solver with random stalls on both
// channels and checks each point pair against a local predictor or its inputs.
// ----------------------------------------------------------------------------
module tb_distance_constraint_solver;

   localparam int CW = dcs_pkg::COORD_WIDTH_DEF;
   localparam longint unsigned DELTA_CAP = 64'h4000_0000_0000_0000;
   localparam longint unsigned Q_LIMIT = 64'd2147483647 + 64'd65536;
   localparam int STALL_LIMIT = 5000;

   typedef enum logic [1:0] {CHK_MODEL, CHK_PASS, CHK_SAME} check_type;

   typedef struct {
      logic signed [CW-1:0] ax, ay, az, bx, by, bz;
      logic [dcs_pkg::REST_W-1:0] rest;
      logic [dcs_pkg::STIFF_W-1:0] stiff;
      logic [dcs_pkg::MASS_W-1:0] ima, imb;
   } link_in_type;

   typedef struct {
      logic signed [CW-1:0] ax, ay, az, bx, by, bz;
      logic degen;
   } link_out_type;

   typedef struct {
      link_in_type li;
      check_type how;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [CW-1:0] req_in_a_x = '0, req_in_a_y = '0, req_in_a_z = '0;
   logic [CW-1:0] req_in_b_x = '0, req_in_b_y = '0, req_in_b_z = '0;
   logic [dcs_pkg::REST_W-1:0] req_rest_length = '0;
   logic [dcs_pkg::STIFF_W-1:0] req_stiffness = '0;
   logic [dcs_pkg::MASS_W-1:0] req_inv_mass_a = '0, req_inv_mass_b = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CW-1:0] rsp_out_a_x, rsp_out_a_y, rsp_out_a_z;
   logic [CW-1:0] rsp_out_b_x, rsp_out_b_y, rsp_out_b_z;
   logic rsp_degenerate;

   link_out_type pending_links[$];
   stim_row_type stim_rows[$];
   int error_count = 0;
   int tx_idle_pct = 11;
   int rx_idle_pct = 63;
   int stall_cycles = 0;

   distance_constraint_solver dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_a_x(req_in_a_x), .req_in_a_y(req_in_a_y), .req_in_a_z(req_in_a_z),
      .req_in_b_x(req_in_b_x), .req_in_b_y(req_in_b_y), .req_in_b_z(req_in_b_z),
      .req_rest_length(req_rest_length), .req_stiffness(req_stiffness),
      .req_inv_mass_a(req_inv_mass_a), .req_inv_mass_b(req_inv_mass_b),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_a_x(rsp_out_a_x), .rsp_out_a_y(rsp_out_a_y), .rsp_out_a_z(rsp_out_a_z),
      .rsp_out_b_x(rsp_out_b_x), .rsp_out_b_y(rsp_out_b_y), .rsp_out_b_z(rsp_out_b_z),
      .rsp_degenerate(rsp_degenerate)
   );

   always #4 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // q16 product, magnitude truncated toward zero and capped
   function automatic longint scaled_product(longint x, longint y);
      logic [127:0] p;
      longint unsigned r;
      p = {64'd0, magnitude(x)} * {64'd0, magnitude(y)};
      p = p >> 16;
      r = (p > {64'd0, DELTA_CAP}) ? DELTA_CAP : p[63:0];
      return ((x < 0) != (y < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi[CW-1:0];
      if (v < lo) return lo[CW-1:0];
      return v[CW-1:0];
   endfunction

   function automatic link_out_type correct_link(link_in_type li);
      longint a[3], b[3], d[3];
      longint unsigned mx, sum, len, q, s1, s2, stf, ima, imb, m;
      longint ratio, ka, kb;
      logic signed [CW-1:0] ra[3], rb[3];
      int sh;
      link_out_type r;
      a[0] = li.ax; a[1] = li.ay; a[2] = li.az;
      b[0] = li.bx; b[1] = li.by; b[2] = li.bz;
      stf = (li.stiff > dcs_pkg::STIFF_ONE) ? 64'd65536 : 64'(li.stiff);
      ima = li.ima;
      imb = li.imb;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = a[i] - b[i];
         if (magnitude(d[i]) > mx) mx = magnitude(d[i]);
      end
      sh = 0;
      while ((mx >> sh) >= (64'd1 << 31)) sh++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m = magnitude(d[i]) >> sh;
         sum += m * m;
      end
      len = floor_root(sum) << sh;
      r.degen = (len == 0 || ima + imb == 0);
      for (int i = 0; i < 3; i++) begin
         ra[i] = a[i][CW-1:0];
         rb[i] = b[i][CW-1:0];
      end
      if (!r.degen) begin
         q = (64'(li.rest) << 16) / len;
         if (q > Q_LIMIT) q = Q_LIMIT;
         ratio = longint'(q) - 65536;
         s1 = (stf * ima) / (ima + imb);
         s2 = stf - s1;
         ka = scaled_product(longint'(s1), ratio);
         kb = scaled_product(longint'(s2), ratio);
         for (int i = 0; i < 3; i++) begin
            ra[i] = clamp_coord(a[i] + scaled_product(d[i], ka));
            rb[i] = clamp_coord(b[i] - scaled_product(d[i], kb));
         end
      end
      r.ax = ra[0]; r.ay = ra[1]; r.az = ra[2];
      r.bx = rb[0]; r.by = rb[1]; r.bz = rb[2];
      return r;
   endfunction

   // ---------------- stimulus ----------------
   function automatic link_in_type make_link(longint ax, longint ay, longint az,
                                             longint bx, longint by, longint bz,
                                             longint rest, longint stiff,
                                             longint ima, longint imb);
      link_in_type li;
      li.ax = ax[CW-1:0]; li.ay = ay[CW-1:0]; li.az = az[CW-1:0];
      li.bx = bx[CW-1:0]; li.by = by[CW-1:0]; li.bz = bz[CW-1:0];
      li.rest = rest[30:0];
      li.stiff = stiff[16:0];
      li.ima = ima[23:0];
      li.imb = imb[23:0];
      return li;
   endfunction

   task automatic add_row(link_in_type li, check_type how);
      stim_row_type row;
      row.li = li;
      row.how = how;
      stim_rows.insert(stim_rows.size(), row);
   endtask

   task automatic expect_link(link_out_type want);
      pending_links.insert(pending_links.size(), want);
   endtask

   function automatic logic [31:0] rand_word();
      return $urandom();
   endfunction

   function automatic link_in_type random_link();
      link_in_type li;
      int mode;
      logic signed [31:0] off;
      mode = $urandom_range(99);
      li.ax = CW'(rand_word()); li.ay = CW'(rand_word()); li.az = CW'(rand_word());
      li.bx = CW'(rand_word()); li.by = CW'(rand_word()); li.bz = CW'(rand_word());
      li.rest = 31'(rand_word());
      li.stiff = 17'($urandom_range(65536));
      li.ima = 24'($urandom_range(1, 24'hFFFFFF));
      li.imb = 24'($urandom_range(1, 24'hFFFFFF));
      if (mode < 70) begin
         // well-formed link: nearby points, rest length on the order of the gap
         li.ax = CW'($signed(rand_word()) >>> $urandom_range(31, 6));
         li.ay = CW'($signed(rand_word()) >>> $urandom_range(31, 6));
         li.az = CW'($signed(rand_word()) >>> $urandom_range(31, 6));
         off = $signed(rand_word()) >>> $urandom_range(31, 8);
         li.bx = CW'(li.ax + off);
         off = $signed(rand_word()) >>> $urandom_range(31, 8);
         li.by = CW'(li.ay + off);
         off = $signed(rand_word()) >>> $urandom_range(31, 8);
         li.bz = CW'(li.az + off);
         li.rest = 31'(rand_word() >> $urandom_range(31, 8));
         li.ima = 24'(rand_word() >> $urandom_range(31, 8));
         li.imb = 24'(rand_word() >> $urandom_range(31, 8));
      end else if (mode < 74) begin
         li.bx = li.ax; li.by = li.ay; li.bz = li.az;
      end else if (mode < 78) begin
         li.ima = '0; li.imb = '0;
      end else if (mode < 82) begin
         li.stiff = 17'(rand_word());
      end else if (mode < 86) begin
         if ($urandom_range(1)) li.ima = '0; else li.imb = '0;
      end
      return li;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   task automatic drive_link(link_in_type li, check_type how);
      link_out_type want;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_a_x <= li.ax; req_in_a_y <= li.ay; req_in_a_z <= li.az;
      req_in_b_x <= li.bx; req_in_b_y <= li.by; req_in_b_z <= li.bz;
      req_rest_length <= li.rest;
      req_stiffness <= li.stiff;
      req_inv_mass_a <= li.ima;
      req_inv_mass_b <= li.imb;
      do @(posedge clock); while (!req_ready);
      if (how == CHK_MODEL) begin
         want = correct_link(li);
      end else begin
         want.ax = li.ax; want.ay = li.ay; want.az = li.az;
         want.bx = li.bx; want.by = li.by; want.bz = li.bz;
         want.degen = (how == CHK_PASS);
      end
      expect_link(want);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_links.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------- response side ----------------
   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= rx_idle_pct);

   always @(posedge clock) begin
      link_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_links.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_out_a_x, 0);
         end else begin
            want = pending_links.pop_front();
            if (rsp_out_a_x !== want.ax) report_mismatch("out_a_x", rsp_out_a_x, want.ax);
            if (rsp_out_a_y !== want.ay) report_mismatch("out_a_y", rsp_out_a_y, want.ay);
            if (rsp_out_a_z !== want.az) report_mismatch("out_a_z", rsp_out_a_z, want.az);
            if (rsp_out_b_x !== want.bx) report_mismatch("out_b_x", rsp_out_b_x, want.bx);
            if (rsp_out_b_y !== want.by) report_mismatch("out_b_y", rsp_out_b_y, want.by);
            if (rsp_out_b_z !== want.bz) report_mismatch("out_b_z", rsp_out_b_z, want.bz);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", rsp_degenerate, want.degen);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_distance_constraint_solver: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      longint mx, mn;
      mx = 64'sh7FFF_FFFF;
      mn = -64'sh8000_0000;
      add_row(make_link(0, 0, 0, 0, 0, 0, 65536, 65536, 65536, 65536), CHK_PASS);
      add_row(make_link(mx, mx, mx, mx, mx, mx, mx, 65536, 1, 1), CHK_PASS);
      add_row(make_link(65536, 131072, 196608, 0, 0, 0, 0, 65536, 0, 0), CHK_PASS);
      add_row(make_link(65536, 0, 0, 0, 0, 0, 65536, 65536, 65536, 65536), CHK_SAME);
      add_row(make_link(65536, 2000, -7, -300, 5, 9, 12345, 0, 65536, 65536), CHK_SAME);
      add_row(make_link(mx, mx, mx, mn, mn, mn, mx, 65536, 24'hFFFFFF, 24'hFFFFFF),
              CHK_MODEL);
      add_row(make_link(mn, mn, mn, mx, mx, mx, 0, 65536, 24'hFFFFFF, 1), CHK_MODEL);
      add_row(make_link(65536, 0, 0, 0, 0, 0, 131072, 17'h1FFFF, 65536, 65536), CHK_MODEL);
      add_row(make_link(100000, -5000, 3, 0, 7, 0, 200000, 40000, 0, 65536), CHK_MODEL);
      add_row(make_link(100000, -5000, 3, 0, 7, 0, 200000, 40000, 65536, 0), CHK_MODEL);
      // tiny gap with huge rest length drives the ratio to its cap
      add_row(make_link(1, 0, 0, 0, 0, 0, mx, 65536, 65536, 65536), CHK_MODEL);
      add_row(make_link(mx, 0, 0, mn, 0, 0, mx, 65536, 1, 1), CHK_MODEL);
      add_row(make_link(-327680, 65536, -131072, 98304, -65536, 32768, 300000,
                        30000, 12345, 54321), CHK_MODEL);
      add_row(make_link(655360, 655360, 0, -655360, 0, 655360, 0, 65536,
                        65536, 65536), CHK_MODEL);
      add_row(make_link(-2, -3, -4, 1, 1, 1, 1, 1, 24'hFFFFFF, 24'hFFFFFF), CHK_MODEL);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) drive_link(stim_rows[i].li, stim_rows[i].how);
      repeat (640) drive_link(random_link(), CHK_MODEL);

      tx_idle_pct = 63;
      rx_idle_pct = 11;
      repeat (630) drive_link(random_link(), CHK_MODEL);

      // hold the sender until the pipeline has fully drained
      req_valid <= 1'b0;
      wait_drained();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      repeat (630) drive_link(random_link(), CHK_MODEL);

      req_valid <= 1'b0;
      wait_drained();
      repeat (120) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_distance_constraint_solver: done, clean");
      end else begin
         $display("tb_distance_constraint_solver: done, errors");
      end
      $finish;
   end

endmodule
